// File: hw/rtl/rnpi_pkg.sv
// Shared types, widths and helpers for the nearest palette index search.
// Used by rnpi_palette, rnpi_dist and rgb15_nearest_palette_index_top.
// No dependencies.
package rnpi_pkg;

    localparam int COMP_W              = 8;
    localparam int CODE_W              = 15;
    localparam int FIELD_W             = 5;
    localparam int SQ_W                = 16;
    localparam int DIST_W              = 18;
    localparam int INDEX_W             = 8;
    localparam int PALETTE_ENTRIES_DEF = 256;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [COMP_W-1:0] comp_t;

    typedef struct packed {
        comp_t red;
        comp_t green;
        comp_t blue;
    } rgb_t;

    // Sideband that travels with one palette entry through the search pipe
    typedef struct packed {
        logic               vld;
        logic               last;
        logic [INDEX_W-1:0] idx;
    } scan_tag_t;

    // Expand each 5-bit field to field*8+4
    function automatic rgb_t expand_code(input logic [CODE_W-1:0] code);
        rgb_t c;
        c.red   = {code[FIELD_W-1:0], 3'b100};
        c.green = {code[2*FIELD_W-1:FIELD_W], 3'b100};
        c.blue  = {code[3*FIELD_W-1:2*FIELD_W], 3'b100};
        return c;
    endfunction

endpackage

// File: hw/rtl/rgb15_nearest_palette_index_top.sv
// Nearest palette index search: top level with sequencer and result register.
// Depends on rnpi_pkg, rnpi_palette and rnpi_dist.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   in      | input     | in_valid/in_stall  | command, entry_index, entry_red/green/blue,
//           |           |                    | color_code
//   out     | output    | out_valid/out_stall| best_index, best_distance
//
// A load transaction writes one palette entry when entry_index is in range.
// A query transaction scans all PALETTE_ENTRIES entries one per cycle through the
// shared distance unit: each entry passes the registered palette read port, then the
// squared-difference register. The result register is loaded once the output register
// is free, and the next transaction is accepted when the sequencer is back in idle.
// in_stall stays high while a query is in progress; the result register lets a new
// transaction in while the previous result still waits on out_stall.
// Reset clears all palette valid bits at once, so every entry reads black with no sweep.
module rgb15_nearest_palette_index_top
    import rnpi_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic [INDEX_W-1:0] entry_index,
    input  logic [COMP_W-1:0]  entry_red,
    input  logic [COMP_W-1:0]  entry_green,
    input  logic [COMP_W-1:0]  entry_blue,
    input  logic [CODE_W-1:0]  color_code,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [INDEX_W-1:0] best_index,
    output logic [DIST_W-1:0]  best_distance
);

    localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(PALETTE_ENTRIES - 1);
    localparam logic [INDEX_W:0]   ENTRY_LIMIT = (INDEX_W+1)'(PALETTE_ENTRIES);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [INDEX_W-1:0] scan_reg;
    logic [INDEX_W-1:0] scan_next;
    scan_tag_t          tag1_reg;
    scan_tag_t          tag0;
    scan_tag_t          tag2;
    rgb_t               target_reg;
    rgb_t               entry_rgb;
    rgb_t               load_rgb;
    logic [DIST_W-1:0]  entry_dist;
    logic [INDEX_W-1:0] best_idx_reg;
    logic [DIST_W-1:0]  best_dist_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [INDEX_W-1:0] out_index_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    logic               in_accept;
    logic               load_wr;
    logic               query_go;
    logic               better;
    logic               out_load;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign load_wr   = in_accept && (command == CMD_LOAD)
                       && ({1'b0, entry_index} < ENTRY_LIMIT);
    assign query_go  = in_accept && (command == CMD_QUERY);
    assign load_rgb  = '{red: entry_red, green: entry_green, blue: entry_blue};

    rnpi_palette #(
        .ENTRIES (PALETTE_ENTRIES),
        .ADDR_W  (ADDR_W)
    ) u_palette (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (load_wr),
        .wr_addr (entry_index[ADDR_W-1:0]),
        .wr_data (load_rgb),
        .rd_addr (scan_reg[ADDR_W-1:0]),
        .rd_data (entry_rgb)
    );

    // Tag the entry being read this cycle; it meets its data in the next cycle
    always_comb
    begin
        tag0.vld  = (state_reg == ST_SCAN);
        tag0.last = (scan_reg == LAST_INDEX);
        tag0.idx  = scan_reg;
    end

    rnpi_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .target   (target_reg),
        .entry    (entry_rgb),
        .tag_in   (tag1_reg),
        .tag_out  (tag2),
        .distance (entry_dist)
    );

    // Strict compare keeps the lowest index on a tie
    assign better   = tag2.vld && (entry_dist < best_dist_reg);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                scan_next = '0;
                if (query_go)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Advance one entry per cycle; stop after the last read is issued
                if (scan_reg == LAST_INDEX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + INDEX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (tag2.vld && tag2.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold the result until the output register is free
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            tag1_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            tag1_reg      <= tag0;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            target_reg    <= expand_code(color_code);
            best_idx_reg  <= '0;
            // All ones exceeds any real distance, so entry 0 always takes over
            best_dist_reg <= '1;
        end
        else if (better)
        begin
            best_idx_reg  <= tag2.idx;
            best_dist_reg <= entry_dist;
        end
        if (out_load)
        begin
            out_index_reg <= best_idx_reg;
            out_dist_reg  <= best_dist_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign best_index    = out_index_reg;
    assign best_distance = out_dist_reg;

endmodule

// File: hw/rtl/rnpi_palette.sv
// Palette store: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as black after reset.
// Depends on rnpi_pkg.
module rnpi_palette
    import rnpi_pkg::*;
#(
    parameter int ENTRIES = PALETTE_ENTRIES_DEF,
    parameter int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  rgb_t              wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output rgb_t              rd_data
);

    rgb_t               mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    rgb_t               rd_data_reg;
    logic               rd_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_hit_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Never-written entries hold reset black
    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

// File: hw/rtl/rnpi_dist.sv
// Shared squared-distance unit: one palette entry per cycle.
// Registers the three squared differences, then sums them.
// Depends on rnpi_pkg.
module rnpi_dist
    import rnpi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rgb_t              target,
    input  rgb_t              entry,
    input  scan_tag_t         tag_in,
    output scan_tag_t         tag_out,
    output logic [DIST_W-1:0] distance
);

    logic [SQ_W-1:0] sq_r_reg;
    logic [SQ_W-1:0] sq_g_reg;
    logic [SQ_W-1:0] sq_b_reg;
    scan_tag_t       tag_reg;
    comp_t           diff_r;
    comp_t           diff_g;
    comp_t           diff_b;

    always_comb
    begin
        diff_r = (target.red   > entry.red)   ? target.red   - entry.red
                                              : entry.red   - target.red;
        diff_g = (target.green > entry.green) ? target.green - entry.green
                                              : entry.green - target.green;
        diff_b = (target.blue  > entry.blue)  ? target.blue  - entry.blue
                                              : entry.blue  - target.blue;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_r_reg <= SQ_W'(diff_r) * SQ_W'(diff_r);
        sq_g_reg <= SQ_W'(diff_g) * SQ_W'(diff_g);
        sq_b_reg <= SQ_W'(diff_b) * SQ_W'(diff_b);
    end

    assign tag_out  = tag_reg;
    assign distance = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);

endmodule
